FILE: src/lmgs_pkg.sv
// Shared types, constants and helper functions for the LED matrix gray-scale scanner.
package lmgs_pkg;

  localparam int PICTURES  = 8;
  localparam int PIC_DEPTH = PICTURES * 64;
  localparam int PIC_AW    = $clog2(PIC_DEPTH);
  localparam int ROWS      = 16;
  localparam int COLS      = 32;
  localparam int LVL_W     = 4;
  localparam int ROW_BITS  = COLS * LVL_W;

  localparam logic [1:0] FN_SET  = 2'd0;
  localparam logic [1:0] FN_LOAD = 2'd1;
  localparam logic [1:0] FN_SCAN = 2'd2;

  localparam logic [1:0] REG_DISPLAY_ON    = 2'd0;
  localparam logic [1:0] REG_PICTURE_MODE  = 2'd1;
  localparam logic [1:0] REG_PICTURE_TOTAL = 2'd2;
  localparam logic [1:0] REG_FRAME_HOLD    = 2'd3;

  localparam logic [31:0] COL_TOP_BIT = 32'h8000_0000;
  localparam logic [3:0]  ROW_MASK    = 4'hF;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  pixel_x;
    logic [3:0]  pixel_y;
    logic [3:0]  level;
    logic [2:0]  picture_index;
    logic [3:0]  picture_row;
    logic [1:0]  plane;
    logic [31:0] plane_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] column_bits;
    logic [3:0]  row_index;
    logic        bank_high;
    logic [2:0]  line_address;
  } out_item_t;

  function automatic logic level_lit(logic [3:0] lev, logic [2:0] sub);
    logic lit;
    case (lev)
      4'd1:    lit = (sub < 3'd1);
      4'd2:    lit = (sub < 3'd2);
      4'd3:    lit = (sub < 3'd4);
      4'd4:    lit = 1'b1;
      default: lit = 1'b0;
    endcase
    return lit;
  endfunction

  function automatic logic [1:0] plane_sel(logic [2:0] sub);
    logic [1:0] p;
    if (sub > 3'd3) p = 2'd3;
    else if (sub > 3'd1) p = 2'd2;
    else if (sub > 3'd0) p = 2'd1;
    else p = 2'd0;
    return p;
  endfunction

endpackage

FILE: src/lmgs_ram.sv
// Generic simple dual-port RAM with registered read.
module lmgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/led_matrix_gray_scan.sv
// LED matrix gray-scale scanner top level: pixel and picture stores, scan sequencer.
// Set pixel and a displayed scan tick each do a registered RAM read, then an update or
// result state; load picture word, ignored items and scans with the display off stay idle.
// A scan result is registered onto out_* as its scan completes; a full output register
// delays completion. Reset clears the counters, state, config registers and per-row valid
// bits of the pixel store at once (no clearing pass); the picture store is not cleared.
module led_matrix_gray_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lmgs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import lmgs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SET  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       display_on_r, picture_mode_r;
  logic [3:0] picture_total_r;
  logic [7:0] frame_hold_r;
  logic [3:0] scan_row_r, scan_row_nxt;
  logic [2:0] subframe_r, subframe_nxt;
  logic [7:0] frm_num_r, frm_num_nxt;
  logic [2:0] cur_pic_r, cur_pic_nxt;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;
  logic       pic_ok_r;
  logic [3:0] set_row_r;
  logic [4:0] set_col_r;
  logic [3:0] set_lvl_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic                accept;
  logic                scan_done;
  logic                pix_re, pix_we;
  logic [3:0]          pix_raddr;
  logic [ROW_BITS-1:0] pix_rdata, pix_wdata, pix_base;
  logic                pic_we;
  logic [PIC_AW-1:0]   pic_waddr, pic_raddr;
  logic [31:0]         pic_rdata;
  logic [31:0]         draw_bits, col_word;
  logic [3:0]          next_pic;
  logic [7:0]          fc_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign scan_done = (state_r == ST_SCAN) && !(out_valid_r && out_stall);

  assign pix_re    = accept && (in_data.func == FN_SET || in_data.func == FN_SCAN);
  assign pix_raddr = (in_data.func == FN_SET) ? ~in_data.pixel_y : scan_row_r;
  assign pix_we    = (state_r == ST_SET);

  assign pic_we    = accept && (in_data.func == FN_LOAD) &&
                     (int'(in_data.picture_index) < PICTURES);
  assign pic_waddr = PIC_AW'({in_data.picture_index, in_data.picture_row, in_data.plane});
  assign pic_raddr = PIC_AW'({cur_pic_r, scan_row_r, plane_sel(subframe_r)});

  lmgs_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (set_row_r),
    .wdata (pix_wdata),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  lmgs_ram #(.WIDTH(32), .DEPTH(PIC_DEPTH)) u_pic_ram (
    .clk   (clk),
    .we    (pic_we),
    .waddr (pic_waddr),
    .wdata (in_data.plane_word),
    .re    (accept && in_data.func == FN_SCAN),
    .raddr (pic_raddr),
    .rdata (pic_rdata)
  );

  always_comb begin
    pix_base = '0;
    if (state_r == ST_SET) begin
      pix_base = row_vld_r[set_row_r] ? pix_rdata : '0;
    end else begin
      pix_base = row_vld_r[scan_row_r] ? pix_rdata : '0;
    end
    pix_wdata = pix_base;
    pix_wdata[{set_col_r, 2'b00} +: LVL_W] = set_lvl_r;
    draw_bits = '0;
    for (int c = 0; c < COLS; c++) begin
      if (level_lit(pix_base[c*LVL_W +: LVL_W], subframe_r)) begin
        draw_bits = draw_bits | (COL_TOP_BIT >> (COLS - 1 - c));
      end
    end
    col_word = picture_mode_r ? (pic_ok_r ? pic_rdata : '0) : draw_bits;
  end

  always_comb begin
    state_nxt     = state_r;
    scan_row_nxt  = scan_row_r;
    subframe_nxt  = subframe_r;
    frm_num_nxt   = frm_num_r;
    cur_pic_nxt   = cur_pic_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    fc_inc        = frm_num_r + 8'd1;
    next_pic      = {1'b0, cur_pic_r} + 4'd1;
    if (next_pic >= picture_total_r) begin
      next_pic = '0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.func == FN_SET) begin
          state_nxt = ST_SET;
        end else if (accept && in_data.func == FN_SCAN && display_on_r) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SET: begin
        row_vld_nxt[set_row_r] = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.column_bits  = col_word;
          out_data_nxt.row_index    = scan_row_r & ROW_MASK;
          out_data_nxt.bank_high    = scan_row_r[3];
          out_data_nxt.line_address = scan_row_r[2:0];
          scan_row_nxt = scan_row_r + 4'd1;
          if (scan_row_r == ROW_MASK) begin
            subframe_nxt = subframe_r + 3'd1;
            if (subframe_r == 3'd7 && picture_mode_r) begin
              if (fc_inc >= frame_hold_r) begin
                frm_num_nxt = '0;
                cur_pic_nxt = next_pic[2:0];
              end else begin
                frm_num_nxt = fc_inc;
              end
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we && cfg_index == REG_PICTURE_MODE && cfg_data[0]) begin
      frm_num_nxt = '0;
      cur_pic_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      display_on_r    <= 1'b1;
      picture_mode_r  <= 1'b0;
      picture_total_r <= 4'd1;
      frame_hold_r    <= 8'd1;
      scan_row_r      <= '0;
      subframe_r      <= '0;
      frm_num_r       <= '0;
      cur_pic_r       <= '0;
      row_vld_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_row_r  <= scan_row_nxt;
      subframe_r  <= subframe_nxt;
      frm_num_r   <= frm_num_nxt;
      cur_pic_r   <= cur_pic_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DISPLAY_ON:    display_on_r    <= cfg_data[0];
          REG_PICTURE_MODE:  picture_mode_r  <= cfg_data[0];
          REG_PICTURE_TOTAL: picture_total_r <= cfg_data[3:0];
          REG_FRAME_HOLD:    frame_hold_r    <= cfg_data;
          default:           display_on_r    <= display_on_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      set_row_r <= ~in_data.pixel_y;
      set_col_r <= in_data.pixel_x ^ 5'h10;
      set_lvl_r <= in_data.level;
      pic_ok_r  <= (int'(cur_pic_r) < PICTURES);
    end
  end

  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_SCAN)
    else $error("result appeared without a scan in progress");

  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> scan_row_r == 4'($past(scan_row_r) + 4'd1))
    else $error("scan row did not advance after a scan");

  a_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SET) |=> row_vld_r[$past(set_row_r)])
    else $error("pixel row not marked valid after write-back");

  a_out_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_data_r.row_index == 4'(scan_row_r - 4'd1))
    else $error("result row does not match scan row");

endmodule

FILE: dv/tb_led_matrix_gray_scan.sv
// Testbench for the LED matrix gray-scale scanner: directed and random transactions.
module tb_led_matrix_gray_scan;
  timeunit 1ns;
  timeprecision 1ps;
  import lmgs_pkg::*;

  localparam logic [1:0] FN_IGNORED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  led_matrix_gray_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [3:0]  lvl_mem   [512];
  logic [31:0] plane_mem [512];
  logic [3:0]  row_ptr     = '0;
  logic [2:0]  sub_ptr     = '0;
  logic [7:0]  frm_num     = '0;
  logic [2:0]  pic_ptr     = '0;
  logic        disp_en     = 1'b1;
  logic        pic_en      = 1'b0;
  logic [3:0]  pic_limit   = 4'd1;
  logic [7:0]  hold_frames = 8'd1;

  out_item_t expected_scans [$];
  int        mismatches = 0;
  bit        idle_on    = 1'b0;
  int        hold_left  = 0;
  int        stall_left = 0;

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] column_word();
    logic [31:0] w;
    logic [3:0]  lim;
    logic [1:0]  pl;
    w = '0;
    if (pic_en) begin
      pl = sub_ptr[2] ? 2'd3 : sub_ptr[1] ? 2'd2 : {1'b0, sub_ptr[0]};
      w  = plane_mem[{pic_ptr, row_ptr, pl}];
    end else begin
      for (int c = 0; c < COLS; c++) begin
        case (lvl_mem[row_ptr * COLS + c])
          4'd1:    lim = 4'd1;
          4'd2:    lim = 4'd2;
          4'd3:    lim = 4'd4;
          4'd4:    lim = 4'd8;
          default: lim = 4'd0;
        endcase
        w[c] = ({1'b0, sub_ptr} < lim);
      end
    end
    return w;
  endfunction

  task automatic apply_to_panel(in_item_t it);
    logic [4:0] col;
    logic [3:0] row;
    logic [4:0] nxt;
    out_item_t  r;
    case (it.func)
      FN_SET: begin
        col = it.pixel_x ^ 5'h10;
        row = ROW_MASK - it.pixel_y;
        lvl_mem[{row, col}] = it.level;
      end
      FN_LOAD: begin
        plane_mem[{it.picture_index, it.picture_row, it.plane}] = it.plane_word;
      end
      FN_SCAN: begin
        if (disp_en) begin
          r.column_bits  = column_word();
          r.row_index    = row_ptr;
          r.bank_high    = row_ptr[3];
          r.line_address = row_ptr[2:0];
          expected_scans.push_back(r);
          row_ptr++;
          if (row_ptr == 4'd0) begin
            sub_ptr++;
            if (sub_ptr == 3'd0 && pic_en) begin
              frm_num++;
              if (frm_num >= hold_frames) begin
                frm_num = '0;
                nxt = {2'b00, pic_ptr} + 5'd1;
                if (nxt >= {1'b0, pic_limit}) nxt = '0;
                pic_ptr = nxt[2:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_scans.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: %h", out_data));
      end else begin
        want = expected_scans.pop_front();
        if (out_data.column_bits !== want.column_bits)
          flag_mismatch($sformatf("column_bits %h, want %h", out_data.column_bits,
                                  want.column_bits));
        if (out_data.row_index !== want.row_index)
          flag_mismatch($sformatf("row_index %0d, want %0d", out_data.row_index,
                                  want.row_index));
        if (out_data.bank_high !== want.bank_high)
          flag_mismatch($sformatf("bank_high %b, want %b", out_data.bank_high,
                                  want.bank_high));
        if (out_data.line_address !== want.line_address)
          flag_mismatch($sformatf("line_address %0d, want %0d", out_data.line_address,
                                  want.line_address));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(3) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t random_item(int set_w, int load_w, int scan_w);
    logic [63:0] raw;
    in_item_t    it;
    int          r;
    raw = {$urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    r   = $urandom_range(99);
    if (r < set_w) it.func = FN_SET;
    else if (r < set_w + load_w) it.func = FN_LOAD;
    else if (r < set_w + load_w + scan_w) it.func = FN_SCAN;
    else it.func = FN_IGNORED;
    if (it.func == FN_SET && $urandom_range(9) < 7) it.level = 4'($urandom_range(4));
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    apply_to_panel(it);
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic scan_tick();
    in_item_t it;
    it      = random_item(0, 0, 100);
    it.func = FN_SCAN;
    send_item(it);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DISPLAY_ON:    disp_en = val[0];
      REG_PICTURE_MODE: begin
        pic_en = val[0];
        if (pic_en) begin
          pic_ptr = '0;
          frm_num = '0;
        end
      end
      REG_PICTURE_TOTAL: pic_limit = val[3:0];
      REG_FRAME_HOLD:    hold_frames = val;
      default: ;
    endcase
  endtask

  task automatic test_pixel_extremes();
    logic [4:0] xs [9] = '{5'd0, 5'd31, 5'd0, 5'd31, 5'd15, 5'd16, 5'd7, 5'd24, 5'd7};
    logic [3:0] ys [9] = '{4'd0, 4'd0, 4'd15, 4'd15, 4'd7, 4'd8, 4'd3, 4'd12, 4'd3};
    logic [3:0] lv [9] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd15, 4'd5, 4'd4, 4'd3, 4'd0};
    in_item_t   it;
    idle_on = 1'b0;
    for (int k = 0; k < 9; k++) begin
      it         = random_item(100, 0, 0);
      it.pixel_x = xs[k];
      it.pixel_y = ys[k];
      it.level   = lv[k];
      send_item(it);
    end
    it         = '1;
    it.func    = FN_IGNORED;
    it.pixel_x = 5'd1;
    it.pixel_y = 4'd2;
    it.level   = 4'd4;
    send_item(it);
    repeat (ROWS) scan_tick();
  endtask

  task automatic test_display_off();
    in_item_t it;
    idle_on = 1'b1;
    repeat (3) scan_tick();
    settle();
    write_reg(REG_DISPLAY_ON, 8'd0);
    repeat (4) scan_tick();
    it         = random_item(100, 0, 0);
    it.pixel_x = 5'd2;
    it.pixel_y = 4'd2;
    it.level   = 4'd4;
    send_item(it);
    settle();
    write_reg(REG_DISPLAY_ON, 8'd1);
    repeat (ROWS) scan_tick();
  endtask

  task automatic test_fill_pictures();
    in_item_t it;
    for (int a = 0; a < PIC_DEPTH; a++) begin
      it      = random_item(0, 100, 0);
      {it.picture_index, it.picture_row, it.plane} = a[8:0];
      if (a == 0) it.plane_word = '0;
      if (a == 1) it.plane_word = '1;
      send_item(it);
    end
  endtask

  task automatic test_picture_basics();
    settle();
    write_reg(REG_PICTURE_TOTAL, 8'd0);
    write_reg(REG_FRAME_HOLD, 8'd0);
    write_reg(REG_PICTURE_MODE, 8'd1);
    repeat (ROWS) scan_tick();
  endtask

  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 300;
    repeat (40) scan_tick();
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_draw();
    settle();
    write_reg(REG_PICTURE_MODE, 8'd0);
    for (int ch = 0; ch < 4; ch++) begin
      settle();
      idle_on = (ch != 1);
      write_reg(REG_DISPLAY_ON, (ch == 2) ? 8'd0 : 8'd1);
      repeat (30) send_item(random_item(40, 5, 50));
    end
  endtask

  task automatic test_random_pictures();
    logic [3:0] totals  [3] = '{4'd15, 4'd0, 4'd5};
    logic [7:0] holds   [3] = '{8'd0, 8'd0, 8'd255};
    bit         restart [3] = '{1'b1, 1'b1, 1'b0};
    int         counts  [3] = '{1080, 140, 40};
    for (int ch = 0; ch < 3; ch++) begin
      settle();
      idle_on = (ch != 2);
      write_reg(REG_DISPLAY_ON, 8'd1);
      write_reg(REG_PICTURE_TOTAL, {4'd0, totals[ch]});
      write_reg(REG_FRAME_HOLD, holds[ch]);
      if (restart[ch]) write_reg(REG_PICTURE_MODE, 8'd1);
      repeat (counts[ch]) send_item(random_item(1, 2, 97));
    end
  endtask

  initial begin
    for (int a = 0; a < 512; a++) begin
      lvl_mem[a]   = '0;
      plane_mem[a] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_pixel_extremes();
    test_display_off();
    test_fill_pictures();
    test_picture_basics();
    test_backpressure();
    test_random_draw();
    test_random_pictures();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_scans.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lmgs_pkg.sv
src/lmgs_ram.sv
src/led_matrix_gray_scan.sv
dv/tb_led_matrix_gray_scan.sv
